[hw/rtl/rotating_queue_move_to_front_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the move-to-front queue
// Shared concurrent assertion helpers; they compile to nothing with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ROTATING_QUEUE_MOVE_TO_FRONT_ASSERT_SVH
`define ROTATING_QUEUE_MOVE_TO_FRONT_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check that is disabled while the synchronous reset is asserted.
`define RQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Clocked check that also holds during reset.
`define RQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RQ_ASSERT_RST(label, clk, rst_n, prop, msg)
`define RQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hw/rtl/rqmtf_pkg.sv]
// ----------------------------------------------------------------------------
// Move-to-front queue package
// Widths, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rqmtf_pkg;

    localparam int ID_W            = 7;
    localparam int ID_MAX          = (1 << ID_W) - 1;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int RESET_COUNT     = 64;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic CMD_SERVE   = 1'b0;
    localparam logic CMD_PROMOTE = 1'b1;

    // Number of slot cells: identifiers never exceed what the count field can hold.
    function automatic int slot_count(input int max_entries);
        int n;
        n = (max_entries < ID_MAX) ? max_entries : ID_MAX;
        return n;
    endfunction

    typedef struct packed {
        logic rebuild;  // restore order 1..count
        logic serve;    // capture head, rotate it to the tail
        logic match;    // compare all cells against the target
        logic shift;    // move the matched entry to the head
    } t_dp_cmd;

    typedef struct packed {
        logic found;    // registered match vector has a hit
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/rqmtf_ctrl.sv]
// ----------------------------------------------------------------------------
// Move-to-front queue controller
// Handshake control, command sequencing and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rotating_queue_move_to_front_assert.svh"

module rqmtf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_command,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rqmtf_pkg::t_dp_cmd      o_cmd,
    input  wire rqmtf_pkg::t_dp_sts i_sts
);
    import rqmtf_pkg::*;

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_PROMOTE = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;

    // A new transaction is taken when idle and the output register is free
    // or being emptied in this cycle.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.rebuild = i_cfg_wr;
        o_cmd.serve   = w_accept && (i_command == CMD_SERVE);
        o_cmd.match   = w_accept && (i_command == CMD_PROMOTE);
        o_cmd.shift   = (r_state == ST_PROMOTE) && i_sts.found;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.match) begin
                    n_state = ST_PROMOTE;
                end
            end
            ST_PROMOTE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.serve) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `RQ_ASSERT_RST(a_serve_sets_valid, i_clk, i_rst_n, o_cmd.serve |=> r_out_valid, "serve lost its result")
    `RQ_ASSERT_RST(a_promote_enters_shift, i_clk, i_rst_n, o_cmd.match |=> (r_state == ST_PROMOTE), "promote skipped shift")
    `RQ_ASSERT_RST(a_shift_one_cycle, i_clk, i_rst_n, (r_state == ST_PROMOTE) |=> (r_state == ST_IDLE), "shift state stuck")
    `RQ_ASSERT_ALWAYS(a_cmd_exclusive, i_clk, !(o_cmd.serve && (o_cmd.match || o_cmd.shift)), "datapath commands overlap")

endmodule

`default_nettype wire

[hw/rtl/rqmtf_dp.sv]
// ----------------------------------------------------------------------------
// Move-to-front queue datapath
// Chain of slot cells with parallel compare, rotate and shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqmtf_dp #(
    parameter int MAX_ENTRIES = rqmtf_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rqmtf_pkg::t_dp_cmd       i_cmd,
    output rqmtf_pkg::t_dp_sts            o_sts,
    input  wire logic [rqmtf_pkg::ID_W-1:0] i_count,
    input  wire logic [rqmtf_pkg::ID_W-1:0] i_target_id,
    output logic [rqmtf_pkg::ID_W-1:0]    o_served_id
);
    import rqmtf_pkg::*;

    localparam int NUM_SLOTS = slot_count(MAX_ENTRIES);
    localparam int POS_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [ID_W-1:0]      w_slot [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] w_hit;
    logic [NUM_SLOTS-1:0] r_match;
    logic [ID_W-1:0]      r_target;
    logic [ID_W-1:0]      r_served;
    logic [ID_W-1:0]      w_last;
    logic [POS_W-1:0]     w_pos;

    assign w_last = i_count - ID_W'(1);

    // The match vector is one-hot, so an OR of the indices gives the position.
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (r_match[k]) begin
                w_pos = w_pos | POS_W'(k);
            end
        end
    end

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        logic [ID_W-1:0] r_cell, n_cell;
        logic [ID_W-1:0] w_next, w_prev;

        if (i < NUM_SLOTS - 1) begin : g_next
            assign w_next = w_slot[i + 1];
        end else begin : g_tail
            assign w_next = r_cell;
        end

        if (i > 0) begin : g_prev
            assign w_prev = w_slot[i - 1];
        end else begin : g_head
            assign w_prev = r_target;
        end

        assign w_slot[i] = r_cell;
        assign w_hit[i]  = (r_cell == i_target_id) && (ID_W'(i) < i_count);

        always_comb begin
            n_cell = r_cell;
            if (i_cmd.serve && (ID_W'(i) < i_count)) begin
                n_cell = (ID_W'(i) == w_last) ? w_slot[0] : w_next;
            end else if (i_cmd.shift && (POS_W'(i) <= w_pos)) begin
                n_cell = w_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.rebuild) begin
                r_cell <= ID_W'(i + 1);
            end else begin
                r_cell <= n_cell;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_match  <= w_hit;
            r_target <= i_target_id;
        end
        if (i_cmd.serve) begin
            r_served <= w_slot[0];
        end
    end

    assign o_sts.found = |r_match;
    assign o_served_id = r_served;

endmodule

`default_nettype wire

[hw/rtl/rotating_queue_move_to_front.sv]
// ----------------------------------------------------------------------------
// Move-to-front queue, top level
// Ordered list of identifiers with serve-and-rotate and promote-to-head.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries a command and a
//   target identifier. A serve transaction returns the head identifier on the
//   output channel (o_out_valid / i_out_ready) and moves that entry to the
//   tail. A promote transaction moves the named entry to the head and returns
//   nothing; an absent identifier leaves the list unchanged.
//   A serve result is shown from the next cycle on, held in an output
//   register. A promote first registers the compare of every slot cell
//   against the target, then shifts the cells ahead of the match. The
//   registered match vector sits between compare and shift, and no new
//   transaction is taken until the shift is done.
//   If the receiver stalls, the result waits in the output register and a new
//   transaction is taken in the same cycle the result is taken.
//   Reset, and every write of entry_count over the APB port, rebuild the order
//   to 1..count. Only pwdata[6:0] is used; a count of 0 is taken as 1 and a
//   count above the slot capacity as the capacity. Reset count is 64, capped at the capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotating_queue_move_to_front #(
    parameter int MAX_ENTRIES = rqmtf_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rqmtf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rqmtf_pkg::DATA_W-1:0] pwdata,
    output logic [rqmtf_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    // Command channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_command,
    input  wire logic [rqmtf_pkg::ID_W-1:0]   i_target_id,
    // Result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [rqmtf_pkg::ID_W-1:0]        o_served_id
);
    import rqmtf_pkg::*;

    localparam int NUM_SLOTS   = slot_count(MAX_ENTRIES);
    localparam int RESET_VALUE = (RESET_COUNT < NUM_SLOTS) ? RESET_COUNT : NUM_SLOTS;

    logic [ID_W-1:0] r_count, n_count;
    logic            w_cfg_wr;
    logic [ID_W-1:0] w_wr_value;
    t_dp_cmd         w_cmd;
    t_dp_sts         w_sts;

    // The register file has a single entry; the write completes in the access
    // phase of the transfer since pready is tied high.
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
    assign w_wr_value = pwdata[ID_W-1:0];

    // Saturate the written count into the range the slot cells can hold.
    always_comb begin
        n_count = w_wr_value;
        if (w_wr_value == '0) begin
            n_count = ID_W'(1);
        end else if (w_wr_value > ID_W'(NUM_SLOTS)) begin
            n_count = ID_W'(NUM_SLOTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ID_W'(RESET_VALUE);
        end else if (w_cfg_wr) begin
            r_count <= n_count;
        end
    end

    // Reads of the count return the saturated value; reads with paddr[2] set return zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ENTRY_COUNT) begin
            prdata = {{(DATA_W - ID_W){1'b0}}, r_count};
        end
    end

    rqmtf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (w_cfg_wr),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // The datapath works with the count in effect for the current
    // transaction; a rebuild ignores it.
    rqmtf_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_count     (r_count),
        .i_target_id (i_target_id),
        .o_served_id (o_served_id)
    );

endmodule

`default_nettype wire
